FILE: hw/rtl/przs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// przs_pkg
// Types and fixed constants shared by the pair ratio z-score signal block.
// ----------------------------------------------------------------------------
package przs_pkg;

   localparam int PRICE_W = 32;
   localparam int RATIO_W = 24;
   localparam int WIN_W   = 7;
   localparam int THR_W   = 16;
   localparam int SUM_W   = 31;   // up to 127 ratios of 24 bits
   localparam int SQ_W    = 55;   // up to 127 squares of 48 bits
   localparam int DVD_W   = 48;   // price A scaled by 2^16

   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

   localparam logic [WIN_W-1:0] WIN_RESET = 7'd20;
   localparam logic [THR_W-1:0] THR_RESET = 16'd512;

   // tick kinds
   localparam logic [1:0] KIND_LEG_A = 2'd0;
   localparam logic [1:0] KIND_LEG_B = 2'd1;

   // order directions
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_BUY  = 2'd1;
   localparam logic [1:0] DIR_SELL = 2'd2;

   // positions
   localparam logic [1:0] POS_NONE  = 2'd0;
   localparam logic [1:0] POS_LONG  = 2'd1;
   localparam logic [1:0] POS_SHORT = 2'd2;
   localparam logic [1:0] POS_FLAT  = 2'd3;

   // register indexes
   localparam logic CSR_WINDOW_LENGTH   = 1'b0;
   localparam logic CSR_ENTRY_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [PRICE_W-1:0] price;
   } req_word_type;

   typedef struct packed {
      logic       leg;
      logic [1:0] direction;
      logic       last;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pair_ratio_zscore_signal_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_ratio_zscore_signal_top
// Pair-trading signal from a rolling z-score of the leg A / leg B price ratio.
// ----------------------------------------------------------------------------
// One tick is taken at a time. An ignored tick (other symbol, or either leg
// price zero) goes back to idle after the check. Once the window is full, a
// tick that forms a ratio is latched and checked, runs through the bit-serial
// ratio divider, then the shared 32x32 multiplier (ten products in turn), and
// is decided last. While the window is still filling, the tick ends after the
// second product. The ratio window lives in a RAM of WINDOW_MAX entries with
// registered read; the old entry is read while the divider runs and
// overwritten afterwards. A pair of signals (leg A, then leg B) is held in
// an output buffer, so the next tick is taken while the pair still drains; a
// decision waits only if the previous pair has not left yet. Writing the
// window length empties the window.
// ----------------------------------------------------------------------------
module pair_ratio_zscore_signal_top #(
   parameter int WINDOW_MAX = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire przs_pkg::req_word_type  req_word,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output przs_pkg::rsp_word_type       rsp_word,
   input  wire                          csr_wr_en,
   input  wire                          csr_index,
   input  wire [przs_pkg::THR_W-1:0]    csr_wdata
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int WCAP  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
   localparam int CMP_W = ((PTR_W > przs_pkg::WIN_W) ? PTR_W : przs_pkg::WIN_W) + 1;
   localparam logic [przs_pkg::WIN_W-1:0] WCAP_V = przs_pkg::WIN_W'(WCAP);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PRICE  = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_MUL    = 5'b01000,
      ST_DECIDE = 5'b10000
   } state_type;

   // multiplier steps
   localparam logic [3:0] MS_OLD_SQ = 4'd0;
   localparam logic [3:0] MS_NEW_SQ = 4'd1;
   localparam logic [3:0] MS_WR     = 4'd2;
   localparam logic [3:0] MS_D2     = 4'd3;
   localparam logic [3:0] MS_WQ_LO  = 4'd4;
   localparam logic [3:0] MS_WQ_HI  = 4'd5;
   localparam logic [3:0] MS_SS     = 4'd6;
   localparam logic [3:0] MS_T2     = 4'd7;
   localparam logic [3:0] MS_TV_LO  = 4'd8;
   localparam logic [3:0] MS_TV_HI  = 4'd9;

   state_type                       state_ff, state_in;
   logic [przs_pkg::PRICE_W-1:0]    price_a_ff, price_a_in;
   logic [przs_pkg::PRICE_W-1:0]    price_b_ff, price_b_in;
   logic                            ign_ff, ign_in;
   logic [przs_pkg::WIN_W-1:0]      win_len_ff, win_len_in;
   logic [przs_pkg::THR_W-1:0]      thr_ff, thr_in;
   logic [PTR_W-1:0]                ptr_ff, ptr_in;
   logic [przs_pkg::WIN_W-1:0]      fill_ff, fill_in;
   logic [przs_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [przs_pkg::SQ_W-1:0]       sq_ff, sq_in;
   logic [1:0]                      pos_ff, pos_in;
   logic                            full_ff, full_in;
   logic [przs_pkg::RATIO_W-1:0]    q_ff, q_in;
   logic [3:0]                      step_ff, step_in;
   logic                            phase_ff, phase_in;
   logic [63:0]                     prod_ff, prod_in;
   logic [przs_pkg::SUM_W-1:0]      mag_ff, mag_in;
   logic                            pos_d_ff, pos_d_in;
   logic                            neg_d_ff, neg_d_in;
   logic [61:0]                     d2_ff, d2_in;
   logic [63:0]                     acc_ff, acc_in;
   logic [31:0]                     t2_ff, t2_in;
   logic [95:0]                     tv_ff, tv_in;
   logic [1:0]                      out_cnt_ff, out_cnt_in;
   logic [1:0]                      dir_a_ff, dir_a_in;
   logic [1:0]                      dir_b_ff, dir_b_in;

   logic [przs_pkg::WIN_W-1:0]      eff_w;
   logic [PTR_W-1:0]                ptr_eff;
   logic [PTR_W-1:0]                ptr_next;
   logic [przs_pkg::RATIO_W-1:0]    old_ratio;
   logic                            ram_rd_en, ram_wr_en;
   logic                            div_start, div_done;
   logic [przs_pkg::RATIO_W-1:0]    div_q;
   logic [31:0]                     mul_x, mul_y;
   logic [przs_pkg::SUM_W-1:0]      wr_val;
   logic                            big, exit_c, v_zero;
   logic                            in_acc, out_acc;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   // effective window: 0 acts as 1, capped at the ring depth and at 127
   always_comb begin
      if (win_len_ff == '0) begin
         eff_w = przs_pkg::WIN_W'(1);
      end else if (win_len_ff > WCAP_V) begin
         eff_w = WCAP_V;
      end else begin
         eff_w = win_len_ff;
      end
   end

   // pointer wrap against the window
   always_comb begin
      ptr_eff  = (CMP_W'(ptr_ff) >= CMP_W'(eff_w)) ? '0 : ptr_ff;
      ptr_next = (CMP_W'(ptr_eff) + CMP_W'(1) >= CMP_W'(eff_w)) ? '0 : ptr_eff + 1'b1;
   end

   przs_ram #(
      .WIDTH (przs_pkg::RATIO_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_eff),
      .wr_data (q_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_eff),
      .rd_data (old_ratio)
   );

   przs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({price_a_ff, 16'h0000}),
      .divisor  (price_b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         MS_OLD_SQ: begin mul_x = 32'(old_ratio); mul_y = 32'(old_ratio); end
         MS_NEW_SQ: begin mul_x = 32'(q_ff);      mul_y = 32'(q_ff); end
         MS_WR:     begin mul_x = 32'(eff_w);     mul_y = 32'(q_ff); end
         MS_D2:     begin mul_x = 32'(mag_ff);    mul_y = 32'(mag_ff); end
         MS_WQ_LO:  begin mul_x = 32'(eff_w);     mul_y = sq_ff[31:0]; end
         MS_WQ_HI:  begin mul_x = 32'(eff_w);     mul_y = 32'(sq_ff[przs_pkg::SQ_W-1:32]); end
         MS_SS:     begin mul_x = 32'(sum_ff);    mul_y = 32'(sum_ff); end
         MS_T2:     begin mul_x = 32'(thr_ff);    mul_y = 32'(thr_ff); end
         MS_TV_LO:  begin mul_x = acc_ff[31:0];   mul_y = t2_ff; end
         MS_TV_HI:  begin mul_x = acc_ff[63:32];  mul_y = t2_ff; end
         default:   begin mul_x = '0;             mul_y = '0; end
      endcase
   end

   // decision terms
   always_comb begin
      wr_val = prod_ff[przs_pkg::SUM_W-1:0];
      v_zero = (acc_ff == '0);
      big    = (tv_ff < {18'h0, d2_ff, 16'h0000});
      exit_c = ({d2_ff, 2'b00} < acc_ff);
   end

   // control and datapath
   always_comb begin
      state_in   = state_ff;
      price_a_in = price_a_ff;
      price_b_in = price_b_ff;
      ign_in     = ign_ff;
      win_len_in = win_len_ff;
      thr_in     = thr_ff;
      ptr_in     = ptr_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      pos_in     = pos_ff;
      full_in    = full_ff;
      q_in       = q_ff;
      step_in    = step_ff;
      phase_in   = phase_ff;
      prod_in    = prod_ff;
      mag_in     = mag_ff;
      pos_d_in   = pos_d_ff;
      neg_d_in   = neg_d_ff;
      d2_in      = d2_ff;
      acc_in     = acc_ff;
      t2_in      = t2_ff;
      tv_in      = tv_ff;
      out_cnt_in = out_cnt_ff;
      dir_a_in   = dir_a_ff;
      dir_b_in   = dir_b_ff;
      ram_rd_en  = 1'b0;
      ram_wr_en  = 1'b0;
      div_start  = 1'b0;
      req_stall  = (state_ff != ST_IDLE);

      // output word drains
      if (out_acc) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               ign_in = 1'b0;
               case (req_word.kind)
                  przs_pkg::KIND_LEG_A: price_a_in = req_word.price;
                  przs_pkg::KIND_LEG_B: price_b_in = req_word.price;
                  default:              ign_in     = 1'b1;
               endcase
               state_in = ST_PRICE;
            end
         end
         ST_PRICE: begin
            if (ign_ff || price_a_ff == '0 || price_b_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               ram_rd_en = 1'b1;
               full_in   = (fill_ff >= eff_w);
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               q_in     = div_q;
               step_in  = MS_OLD_SQ;
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!phase_ff) begin
               prod_in  = {32'h0, mul_x} * {32'h0, mul_y};
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               step_in  = step_ff + 1'b1;
               case (step_ff)
                  MS_OLD_SQ: begin
                     if (full_ff) begin
                        sum_in = sum_ff - przs_pkg::SUM_W'(old_ratio);
                        sq_in  = sq_ff - przs_pkg::SQ_W'(prod_ff[47:0]);
                     end
                  end
                  MS_NEW_SQ: begin
                     sum_in    = sum_ff + przs_pkg::SUM_W'(q_ff);
                     sq_in     = sq_ff + przs_pkg::SQ_W'(prod_ff[47:0]);
                     ram_wr_en = 1'b1;
                     ptr_in    = ptr_next;
                     fill_in   = full_ff ? eff_w : fill_ff + 1'b1;
                     // window still filling: no test this tick
                     if (!full_ff && (fill_ff + 1'b1 < eff_w)) begin
                        state_in = ST_IDLE;
                     end
                  end
                  MS_WR: begin
                     pos_d_in = (wr_val > sum_ff);
                     neg_d_in = (wr_val < sum_ff);
                     mag_in   = (wr_val > sum_ff) ? wr_val - sum_ff : sum_ff - wr_val;
                  end
                  MS_D2:    d2_in  = prod_ff[61:0];
                  MS_WQ_LO: acc_in = prod_ff;
                  MS_WQ_HI: acc_in = acc_ff + {prod_ff[31:0], 32'h0};
                  MS_SS:    acc_in = acc_ff - prod_ff;
                  MS_T2:    t2_in  = prod_ff[31:0];
                  MS_TV_LO: tv_in  = {32'h0, prod_ff};
                  MS_TV_HI: begin
                     tv_in    = tv_ff + {prod_ff, 32'h0};
                     state_in = ST_DECIDE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DECIDE: begin
            // previous pair must have left the buffer
            if (out_cnt_ff == '0) begin
               state_in = ST_IDLE;
               if (!v_zero) begin
                  if (pos_d_ff && big && pos_ff != przs_pkg::POS_SHORT) begin
                     dir_a_in   = przs_pkg::DIR_SELL;
                     dir_b_in   = przs_pkg::DIR_BUY;
                     pos_in     = przs_pkg::POS_SHORT;
                     out_cnt_in = 2'd2;
                  end else if (neg_d_ff && big && pos_ff != przs_pkg::POS_LONG) begin
                     dir_a_in   = przs_pkg::DIR_BUY;
                     dir_b_in   = przs_pkg::DIR_SELL;
                     pos_in     = przs_pkg::POS_LONG;
                     out_cnt_in = 2'd2;
                  end else if (exit_c && pos_ff != przs_pkg::POS_FLAT) begin
                     dir_a_in   = przs_pkg::DIR_NONE;
                     dir_b_in   = przs_pkg::DIR_NONE;
                     pos_in     = przs_pkg::POS_FLAT;
                     out_cnt_in = 2'd2;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes; window length change empties the window
      if (csr_wr_en) begin
         case (csr_index)
            przs_pkg::CSR_WINDOW_LENGTH: begin
               win_len_in = csr_wdata[przs_pkg::WIN_W-1:0];
               ptr_in     = '0;
               fill_in    = '0;
               sum_in     = '0;
               sq_in      = '0;
            end
            przs_pkg::CSR_ENTRY_THRESHOLD: thr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         price_a_ff <= '0;
         price_b_ff <= '0;
         win_len_ff <= przs_pkg::WIN_RESET;
         thr_ff     <= przs_pkg::THR_RESET;
         ptr_ff     <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
         sq_ff      <= '0;
         pos_ff     <= przs_pkg::POS_NONE;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         price_a_ff <= price_a_in;
         price_b_ff <= price_b_in;
         win_len_ff <= win_len_in;
         thr_ff     <= thr_in;
         ptr_ff     <= ptr_in;
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         sq_ff      <= sq_in;
         pos_ff     <= pos_in;
         out_cnt_ff <= out_cnt_in;
      end
      ign_ff   <= ign_in;
      full_ff  <= full_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      phase_ff <= phase_in;
      prod_ff  <= prod_in;
      mag_ff   <= mag_in;
      pos_d_ff <= pos_d_in;
      neg_d_ff <= neg_d_in;
      d2_ff    <= d2_in;
      acc_ff   <= acc_in;
      t2_ff    <= t2_in;
      tv_ff    <= tv_in;
      dir_a_ff <= dir_a_in;
      dir_b_ff <= dir_b_in;
   end

   // result word: leg A word first, then leg B
   always_comb begin
      rsp_valid          = (out_cnt_ff != '0);
      rsp_word.leg       = (out_cnt_ff == 2'd1);
      rsp_word.last      = (out_cnt_ff == 2'd1);
      rsp_word.direction = (out_cnt_ff == 2'd2) ? dir_a_ff : dir_b_ff;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/przs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// przs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module przs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/przs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// przs_div
// Restoring divider, one quotient bit a cycle. Forms (A << 16) / B and
// saturates the quotient to the ratio width.
// ----------------------------------------------------------------------------
module przs_div (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire [przs_pkg::DVD_W-1:0]            dividend,
   input  wire [przs_pkg::PRICE_W-1:0]          divisor,
   output logic                                 done,
   output logic [przs_pkg::RATIO_W-1:0]         quotient
);

   localparam int CNT_W = $clog2(przs_pkg::DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(przs_pkg::DVD_W - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [przs_pkg::PRICE_W-1:0] rem_ff, rem_in;
   logic [przs_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [przs_pkg::PRICE_W-1:0] dsr_ff, dsr_in;
   logic [przs_pkg::PRICE_W:0]   rem_sh;
   logic [przs_pkg::PRICE_W:0]   rem_sub;
   logic                         ge;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[przs_pkg::DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      ge      = (rem_sh >= {1'b0, dsr_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[przs_pkg::PRICE_W-1:0] : rem_sh[przs_pkg::PRICE_W-1:0];
         dvd_in = {dvd_ff[przs_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   // quotient lives in the shifted dividend once finished
   assign done     = done_ff;
   assign quotient = (|dvd_ff[przs_pkg::DVD_W-1:przs_pkg::RATIO_W]) ? przs_pkg::RATIO_MAX
                     : dvd_ff[przs_pkg::RATIO_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/przs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// przs_checker
// Port-level checks for the pair ratio z-score signal block.
// ----------------------------------------------------------------------------
module przs_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire przs_pkg::rsp_word_type  rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // one tick at a time: the cycle after a tick is taken the input stalls
   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken in back-to-back cycles");

   // leg B word follows leg A word at once
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_word.last |=> rsp_valid && rsp_word.last)
      else $error("second word of pair missing");

   // leg A carries the first word, leg B the last
   a_leg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.leg == rsp_word.last && rsp_word.direction != 2'd3)
      else $error("bad leg or direction in result word");

endmodule

bind pair_ratio_zscore_signal_top przs_checker u_przs_checker (.*);

`default_nettype wire
